/* design/mcbc_pkg.sv */
package mcbc_pkg;

  localparam logic [7:0] PRELOAD       = 8'hFE;
  localparam logic [7:0] FOREVER_LIMIT = 8'd100;

  typedef enum logic {
    MODE_TICK = 1'b0,
    MODE_CMD  = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMD,
    ST_TICK
  } state_e;

  // One channel's stored state, one memory word.
  typedef struct packed {
    logic [7:0] phase;
    logic       endless;
    logic [7:0] toggles;
    logic [7:0] counter;
    logic       level;
  } chan_entry_t;

  typedef struct packed {
    chan_entry_t entry;
    logic        finished;
  } chan_update_t;

endpackage

/* design/multi_channel_blink_controller.sv */
// A tick's first result passes the memory read register and then the output register; then
//   one result per cycle follows while the output does not stall. A sweep is one read of the
//   channel memory plus one read-modify-write per channel; a command waits for a free output.
// Throughput: one item at a time, set by the single read and write port of the memory.
// Reset: asynchronous, active low; all channels read as off and inactive right away.
module multi_channel_blink_controller
  import mcbc_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // channel[2:0], blink_count[10:3], half_period[18:11]
  input  logic        s_axis_tuser,   // mode[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_channel[2:0], level[3], finished[4]
  output logic        m_axis_tlast
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);
  localparam int EW = $bits(chan_entry_t);

  // Input field split.
  logic [2:0] in_ch;
  logic [7:0] in_count;
  logic [7:0] in_half;
  logic       in_accept;
  logic       in_range;

  assign in_ch     = s_axis_tdata[2:0];
  assign in_count  = s_axis_tdata[10:3];
  assign in_half   = s_axis_tdata[18:11];
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign in_range  = (32'(in_ch) < CHANNELS);

  state_e state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] cmd_ch_q, cmd_ch_d;
  logic [7:0]       cmd_count_q, cmd_count_d;
  logic [7:0]       cmd_half_q, cmd_half_d;

  // Per-entry written marks; an unwritten entry reads as off and inactive.
  logic [CHANNELS-1:0] valid_q, valid_d;
  logic                rd_valid_q, rd_valid_d;

  // Memory port signals.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  chan_entry_t      ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [EW-1:0]    ram_rdata;

  chan_entry_t  rd_entry;
  chan_update_t upd;

  // Output register.
  logic       m_valid_q, m_valid_d;
  logic [7:0] m_data_q, m_data_d;
  logic       m_last_q, m_last_d;
  logic       out_free;
  logic       out_load;

  assign out_free = !m_valid_q || m_axis_tready;

  mcbc_ram #(
    .WIDTH(EW),
    .DEPTH(CHANNELS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    rd_entry = chan_entry_t'(ram_rdata);
    if (!rd_valid_q) begin
      rd_entry.endless = 1'b0;
      rd_entry.toggles = 8'd0;
      rd_entry.counter = 8'd0;
      rd_entry.level   = 1'b0;
    end
  end

  mcbc_update u_update (
    .entry_i(rd_entry),
    .upd_o  (upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      valid_q    <= '0;
      m_valid_q  <= 1'b0;
      rd_valid_q <= 1'b0;
      idx_q      <= '0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      m_valid_q  <= m_valid_d;
      rd_valid_q <= rd_valid_d;
      idx_q      <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_ch_q    <= cmd_ch_d;
    cmd_count_q <= cmd_count_d;
    cmd_half_q  <= cmd_half_d;
    m_data_q    <= m_data_d;
    m_last_q    <= m_last_d;
  end

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    cmd_ch_d      = cmd_ch_q;
    cmd_count_d   = cmd_count_q;
    cmd_half_d    = cmd_half_q;
    valid_d       = valid_q;
    rd_valid_d    = rd_valid_q;
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = idx_q;
    ram_wdata     = upd.entry;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    out_load      = 1'b0;
    m_data_d      = m_data_q;
    m_last_d      = m_last_q;

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_accept) begin
          if (mode_e'(s_axis_tuser) == MODE_CMD) begin
            // Drop commands for channels that do not exist.
            if (in_range) begin
              cmd_ch_d    = IDX_W'(in_ch);
              cmd_count_d = in_count;
              cmd_half_d  = in_half;
              state_d     = ST_CMD;
            end
          end else begin
            // Start the sweep: fetch channel zero.
            ram_re     = 1'b1;
            ram_raddr  = '0;
            rd_valid_d = valid_q[0];
            idx_d      = '0;
            state_d    = ST_TICK;
          end
        end
      end

      ST_CMD: begin
        // Hold the command until the output register can take its result.
        if (out_free) begin
          ram_we            = 1'b1;
          ram_waddr         = cmd_ch_q;
          ram_wdata.phase   = cmd_half_q;
          ram_wdata.counter = PRELOAD;
          ram_wdata.level   = 1'b0;
          if (cmd_count_q > FOREVER_LIMIT) begin
            ram_wdata.endless = 1'b1;
            ram_wdata.toggles = 8'd0;
          end else begin
            ram_wdata.endless = 1'b0;
            ram_wdata.toggles = {cmd_count_q[6:0], 1'b0};
          end
          valid_d[cmd_ch_q] = 1'b1;
          out_load          = 1'b1;
          m_data_d          = {5'b0, 3'(cmd_ch_q)};
          m_last_d          = 1'b1;
          state_d           = ST_IDLE;
        end
      end

      ST_TICK: begin
        // Read data for idx_q is waiting; write it back and fetch the next channel.
        // While the output stalls, the memory read register holds its word.
        if (out_free) begin
          ram_we         = 1'b1;
          ram_waddr      = idx_q;
          ram_wdata      = upd.entry;
          valid_d[idx_q] = 1'b1;
          out_load       = 1'b1;
          m_data_d       = {3'b0, upd.finished, upd.entry.level, 3'(idx_q)};
          m_last_d       = (idx_q == LAST_IDX);
          if (idx_q == LAST_IDX) begin
            state_d = ST_IDLE;
          end else begin
            ram_re     = 1'b1;
            ram_raddr  = idx_q + IDX_W'(1);
            rd_valid_d = valid_q[idx_q + IDX_W'(1)];
            idx_d      = idx_q + IDX_W'(1);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  // The sweep never writes the entry it is fetching in the same cycle.
  a_no_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("write and read hit the same channel entry");

  // The result for the final channel ends the sweep.
  a_sweep_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TICK && out_load && idx_q == LAST_IDX) |=> (state_q == ST_IDLE))
    else $error("tick sweep did not end after the final channel");

  // A tick transfer starts a sweep at channel zero.
  a_tick_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !s_axis_tuser) |=> (state_q == ST_TICK && idx_q == '0))
    else $error("tick transfer did not start a sweep");

endmodule

/* design/mcbc_ram.sv */
module mcbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/mcbc_update.sv */
module mcbc_update
  import mcbc_pkg::*;
(
  input  chan_entry_t  entry_i,
  output chan_update_t upd_o
);

  logic       active;
  logic [7:0] cnt_inc;
  logic [7:0] tog_dec;

  assign active  = entry_i.endless || (entry_i.toggles != 8'd0);
  assign cnt_inc = entry_i.counter + 8'd1;
  assign tog_dec = entry_i.toggles - 8'd1;

  always_comb begin
    upd_o.entry    = entry_i;
    upd_o.finished = 1'b0;
    if (active) begin
      upd_o.entry.counter = cnt_inc;
      // Phase over: restart the counter and flip the pin.
      if (cnt_inc > entry_i.phase) begin
        upd_o.entry.counter = 8'd1;
        upd_o.entry.level   = ~entry_i.level;
        if (!entry_i.endless) begin
          upd_o.entry.toggles = tog_dec;
          upd_o.finished      = (tog_dec == 8'd0);
        end
      end
    end
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import mcbc_pkg::*;

  localparam int NUM_CHANNELS = 8;
  localparam int QUIET_LIMIT  = 5000;  // cycles with no transfer on either side
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_ITEMS = 47;    // per idling phase

  typedef struct {
    mode_e       mode;
    logic [2:0]  chan;
    logic [7:0]  count;
    logic [7:0]  half;
    int unsigned idle_pct;   // chance in percent that the sender idles a cycle
    int unsigned stall_pct;  // chance in percent that the receiver stalls a cycle
    bit          drain_first;
  } blink_req_t;

  typedef struct packed {
    logic [2:0] chan;
    logic       level;
    logic       finished;
    logic       last;
  } led_report_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = MODE_TICK;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  multi_channel_blink_controller #(
    .CHANNELS(NUM_CHANNELS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of every channel's blink state.
  logic [7:0] shadow_level   [NUM_CHANNELS];
  logic [7:0] shadow_counter [NUM_CHANNELS];
  logic [7:0] shadow_toggles [NUM_CHANNELS];
  logic       shadow_forever [NUM_CHANNELS];
  logic [7:0] shadow_phase   [NUM_CHANNELS];

  blink_req_t  pending_reqs[$];
  led_report_t expected_reports[$];
  blink_req_t  req_on_bus;

  int unsigned stall_pct    = 0;
  int unsigned items_total  = 0;
  int unsigned items_sent   = 0;
  int unsigned ticks_sent   = 0;
  int unsigned cmds_sent    = 0;
  int unsigned reports_seen = 0;
  int unsigned finish_seen  = 0;
  int unsigned errors       = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      shadow_level[i]   = '0;
      shadow_counter[i] = '0;
      shadow_toggles[i] = '0;
      shadow_forever[i] = 1'b0;
      shadow_phase[i]   = '0;
    end
  end

  // Advance the shadow state by one accepted item and queue the reports it causes.
  function automatic void advance_blink_state(blink_req_t r);
    logic fin;
    if (r.mode == MODE_CMD) begin
      cmds_sent++;
      shadow_level[r.chan]   = '0;
      shadow_counter[r.chan] = PRELOAD;
      if (r.count > FOREVER_LIMIT) begin
        shadow_forever[r.chan] = 1'b1;
        shadow_toggles[r.chan] = '0;
      end else begin
        shadow_forever[r.chan] = 1'b0;
        shadow_toggles[r.chan] = {r.count[6:0], 1'b0};
      end
      shadow_phase[r.chan] = r.half;
      expected_reports.push_back('{r.chan, 1'b0, 1'b0, 1'b1});
    end else begin
      ticks_sent++;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        fin = 1'b0;
        if (shadow_forever[i] || shadow_toggles[i] != 0) begin
          shadow_counter[i] = shadow_counter[i] + 8'd1;
          if (shadow_counter[i] > shadow_phase[i]) begin
            shadow_counter[i] = 8'd1;
            shadow_level[i][0] = ~shadow_level[i][0];
            if (!shadow_forever[i]) begin
              shadow_toggles[i] = shadow_toggles[i] - 8'd1;
              fin = (shadow_toggles[i] == 0);
            end
          end
        end
        expected_reports.push_back('{i[2:0], shadow_level[i][0], fin,
                                     i == NUM_CHANNELS - 1});
      end
    end
  endfunction

  function automatic blink_req_t make_req(mode_e mode, logic [2:0] chan, logic [7:0] count,
                                          logic [7:0] half);
    blink_req_t r;
    r.mode        = mode;
    r.chan        = chan;
    r.count       = count;
    r.half        = half;
    r.idle_pct    = 0;
    r.stall_pct   = 0;
    r.drain_first = 1'b0;
    return r;
  endfunction

  // Commands pick short finite blinks in four cases of ten and short phases in six of ten,
  // so sequences run to completion; the rest covers forever, stop and the full field ranges.
  function automatic blink_req_t random_req();
    blink_req_t r;
    int unsigned pick;
    r = make_req($urandom_range(99) < 55 ? MODE_TICK : MODE_CMD,
                 3'($urandom_range(7)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    if (r.mode == MODE_CMD) begin
      pick = $urandom_range(9);
      case (pick)
        0:       r.count = 8'd0;
        5:       r.count = FOREVER_LIMIT;
        6:       r.count = FOREVER_LIMIT + 8'd1;
        7:       r.count = 8'($urandom_range(101, 255));
        8, 9:    r.count = 8'($urandom_range(255));
        default: r.count = 8'($urandom_range(1, 4));
      endcase
      pick = $urandom_range(9);
      case (pick)
        6:       r.half = 8'd255;
        7:       r.half = 8'd0;
        8, 9:    r.half = 8'($urandom_range(255));
        default: r.half = 8'($urandom_range(3));
      endcase
    end
    return r;
  endfunction

  task automatic flag_error(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Driver: hold the offered item until its transfer, then pick the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    bit offer;
    blink_req_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= MODE_TICK;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        advance_blink_state(req_on_bus);
        items_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        offer = 1'b0;
        if (pending_reqs.size() != 0) begin
          if (pending_reqs[0].drain_first)
            offer = (expected_reports.size() == 0);
          else
            offer = ($urandom_range(99) >= pending_reqs[0].idle_pct);
        end
        if (offer) begin
          nxt = pending_reqs.pop_front();
          req_on_bus = nxt;
          stall_pct <= nxt.stall_pct;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {5'b0, nxt.half, nxt.count, nxt.chan};
          s_axis_tuser  <= nxt.mode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer against the oldest expected report.
  always @(posedge clk_i or negedge rst_ni) begin
    led_report_t got;
    led_report_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[2:0], m_axis_tdata[3], m_axis_tdata[4], m_axis_tlast};
        reports_seen++;
        if (expected_reports.size() == 0) begin
          flag_error($sformatf("unexpected result chan=%0d level=%0b finished=%0b last=%0b",
                               got.chan, got.level, got.finished, got.last));
        end else begin
          want = expected_reports.pop_front();
          if (want.finished) finish_seen++;
          if (got.chan != want.chan || got.level != want.level ||
              got.finished != want.finished || got.last != want.last)
            flag_error($sformatf({"result mismatch: expected chan=%0d level=%0b ",
                                  "finished=%0b last=%0b, got chan=%0d level=%0b ",
                                  "finished=%0b last=%0b"},
                                 want.chan, want.level, want.finished, want.last,
                                 got.chan, got.level, got.finished, got.last));
        end
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: count cycles with no transfer on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("multi_channel_blink_controller regression: fail");
    $finish;
  end

  initial begin
    int unsigned idle_by_phase[4];
    int unsigned stall_by_phase[4];
    blink_req_t r;
    idle_by_phase  = '{0, 81, 0, 29};
    stall_by_phase = '{0, 0, 81, 29};

    // Directed: idle tick, shortest finite blink, forever with wrap-around,
    // forever just above the limit, longest finite blink, stop, high bits.
    pending_reqs.push_back(make_req(MODE_TICK, 3'd0, 8'd0,   8'd0));
    pending_reqs.push_back(make_req(MODE_CMD,  3'd0, 8'd1,   8'd0));
    pending_reqs.push_back(make_req(MODE_CMD,  3'd7, 8'd255, 8'd255));
    pending_reqs.push_back(make_req(MODE_CMD,  3'd1, 8'd101, 8'd1));
    pending_reqs.push_back(make_req(MODE_CMD,  3'd2, 8'd100, 8'd2));
    pending_reqs.push_back(make_req(MODE_CMD,  3'd3, 8'd0,   8'd5));
    pending_reqs.push_back(make_req(MODE_CMD,  3'd4, 8'd2,   8'd128));
    repeat (4) pending_reqs.push_back(make_req(MODE_TICK, 3'd7, 8'd255, 8'd255));
    // Stop a channel in the middle of its blink, then start a fast one.
    pending_reqs.push_back(make_req(MODE_CMD,  3'd2, 8'd0,   8'd0));
    pending_reqs.push_back(make_req(MODE_CMD,  3'd5, 8'd3,   8'd0));
    repeat (6) pending_reqs.push_back(make_req(MODE_TICK, 3'd0, 8'd0, 8'd0));
    pending_reqs.push_back(make_req(MODE_CMD,  3'd6, 8'd127, 8'd170));
    pending_reqs.push_back(make_req(MODE_CMD,  3'd4, 8'd85,  8'd85));
    repeat (2) pending_reqs.push_back(make_req(MODE_TICK, 3'd5, 8'd170, 8'd85));

    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
        r = random_req();
        r.idle_pct    = idle_by_phase[p];
        r.stall_pct   = stall_by_phase[p];
        r.drain_first = (k == 0);  // hold off until every pending result is back
        pending_reqs.push_back(r);
      end
    end
    items_total = pending_reqs.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_sent != items_total || expected_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d ticks and %0d blink commands over four idling phases;",
             ticks_sent, cmds_sent);
    $display("checked %0d results, %0d of them ending a finite blink, %0d errors.",
             reports_seen, finish_seen, errors);
    if (errors == 0)
      $display("multi_channel_blink_controller regression: pass");
    else
      $display("multi_channel_blink_controller regression: fail");
    $finish;
  end

endmodule

/* sim.f */
design/mcbc_pkg.sv
design/mcbc_ram.sv
design/mcbc_update.sv
design/multi_channel_blink_controller.sv
tb/sv/testbench.sv
